@@ rtl/afg_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// afg_pkg
// shared types and constants of the fade and gain stage
// ----------------------------------------------------------------------------
package afg_pkg;

    localparam int SAMPLE_BITS        = 16;
    localparam int POSITION_BITS      = 31;
    localparam int RAMP_FRACTION_BITS = 16;

    localparam int LEN_BITS   = 31;
    localparam int GAIN_BITS  = 16;
    localparam int GAIN_FRAC  = 14;
    localparam int CFG_BITS   = 31;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [GAIN_BITS-1:0] GAIN_UNITY = 16'd16384;
    localparam logic [GAIN_BITS-1:0] GAIN_MAX   = 16'd32768;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_TRACK_LEN    = 3'd0,
        REG_FADE_IN_LEN  = 3'd1,
        REG_FADE_OUT_LEN = 3'd2,
        REG_GAIN         = 3'd3,
        REG_GAIN_ENABLED = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic                 neg;
        logic                 beyond;
        logic                 fade_in_on;
        logic                 fade_out_on;
    } flags_t;

    typedef struct packed {
        logic [LEN_BITS-1:0]  fade_in_len;
        logic [LEN_BITS-1:0]  fade_out_len;
        logic [GAIN_BITS-1:0] gain_eff;
        logic                 gain_on;
    } cfg_t;

endpackage
`default_nettype wire

@@ rtl/audio_fade_gain_stage_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// audio_fade_gain_stage_core
// linear fade-in, fade-out and constant gain with saturation per pcm sample
// ----------------------------------------------------------------------------
//  channel | dir | transaction
//  s_      | in  | tdata: sample_in, position
//  m_      | out | tdata: sample_out; tuser: beyond_end
//  cfg_    | in  | register write, index and data
//
//  one sample per cycle sustained; one-bit-per-stage ramp dividers, then
//  three multiply stages
//  synchronous active-low reset empties queue and pipeline
//  an m_ stall holds the whole arithmetic pipeline; the queue absorbs two
// ----------------------------------------------------------------------------
module audio_fade_gain_stage_core #(
    parameter int SAMPLE_BITS        = afg_pkg::SAMPLE_BITS,
    parameter int POSITION_BITS      = afg_pkg::POSITION_BITS,
    parameter int RAMP_FRACTION_BITS = afg_pkg::RAMP_FRACTION_BITS,
    parameter int S_DATA_BITS        = ((SAMPLE_BITS + POSITION_BITS + 7) / 8) * 8,
    parameter int M_DATA_BITS        = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [afg_pkg::CFG_IDX_BITS-1:0] cfg_addr,
    input  wire logic [afg_pkg::CFG_BITS-1:0]     cfg_wdata,
    input  wire logic                             s_tvalid,
    output      logic                             s_tready,
    input  wire logic [S_DATA_BITS-1:0]           s_tdata,  // sample_in, position
    output      logic                             m_tvalid,
    input  wire logic                             m_tready,
    output      logic [M_DATA_BITS-1:0]           m_tdata,  // sample_out
    output      logic [0:0]                       m_tuser   // beyond_end
);
    localparam int ITEM_BITS = 4 + SAMPLE_BITS + 2 * afg_pkg::LEN_BITS;

    logic [ITEM_BITS-1:0]   item, q_item;
    afg_pkg::cfg_t          cfg;
    logic                   q_valid, q_ready;
    logic [SAMPLE_BITS-1:0] sample_out;
    logic                   beyond_end;

    afg_front #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .POSITION_BITS (POSITION_BITS),
        .ITEM_BITS     (ITEM_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .sample_in (s_tdata[SAMPLE_BITS-1:0]),
        .position  (s_tdata[SAMPLE_BITS +: POSITION_BITS]),
        .item      (item),
        .cfg       (cfg)
    );

    afg_queue #(
        .WIDTH (ITEM_BITS)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s_tvalid),
        .wr_ready (s_tready),
        .wr_data  (item),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_item)
    );

    afg_back #(
        .SAMPLE_BITS        (SAMPLE_BITS),
        .RAMP_FRACTION_BITS (RAMP_FRACTION_BITS),
        .ITEM_BITS          (ITEM_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (q_valid),
        .in_ready   (q_ready),
        .in_item    (q_item),
        .cfg        (cfg),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_sample (sample_out),
        .out_beyond (beyond_end)
    );

    assign m_tdata    = M_DATA_BITS'(sample_out);
    assign m_tuser[0] = beyond_end;
endmodule
`default_nettype wire

@@ rtl/afg_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// afg_front
// configuration registers and per-sample classification
// ----------------------------------------------------------------------------
module afg_front #(
    parameter int SAMPLE_BITS   = afg_pkg::SAMPLE_BITS,
    parameter int POSITION_BITS = afg_pkg::POSITION_BITS,
    parameter int ITEM_BITS     = 4 + SAMPLE_BITS + 2 * afg_pkg::LEN_BITS
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_we,
    input  wire logic [afg_pkg::CFG_IDX_BITS-1:0]   cfg_addr,
    input  wire logic [afg_pkg::CFG_BITS-1:0]       cfg_wdata,
    input  wire logic [SAMPLE_BITS-1:0]             sample_in,
    input  wire logic [POSITION_BITS-1:0]           position,
    output      logic [ITEM_BITS-1:0]               item,
    output      afg_pkg::cfg_t                      cfg
);
    localparam int LB = afg_pkg::LEN_BITS;
    localparam int CW = (POSITION_BITS > LB) ? POSITION_BITS : LB;

    logic [LB-1:0]                 track_len_reg, fade_in_reg, fade_out_reg;
    logic [afg_pkg::GAIN_BITS-1:0] gain_reg;
    logic                          gain_en_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            track_len_reg <= '0;
            fade_in_reg   <= '0;
            fade_out_reg  <= '0;
            gain_reg      <= afg_pkg::GAIN_UNITY;
            gain_en_reg   <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                afg_pkg::REG_TRACK_LEN:    track_len_reg <= cfg_wdata[LB-1:0];
                afg_pkg::REG_FADE_IN_LEN:  fade_in_reg   <= cfg_wdata[LB-1:0];
                afg_pkg::REG_FADE_OUT_LEN: fade_out_reg  <= cfg_wdata[LB-1:0];
                afg_pkg::REG_GAIN:
                    gain_reg <= cfg_wdata[afg_pkg::GAIN_BITS-1:0];
                afg_pkg::REG_GAIN_ENABLED: gain_en_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    logic [afg_pkg::GAIN_BITS-1:0] gain_eff;
    assign gain_eff = (gain_reg > afg_pkg::GAIN_MAX) ? afg_pkg::GAIN_MAX : gain_reg;

    always_comb begin
        cfg.fade_in_len  = fade_in_reg;
        cfg.fade_out_len = fade_out_reg;
        cfg.gain_eff     = gain_eff;
        cfg.gain_on      = gain_en_reg && (gain_eff != afg_pkg::GAIN_UNITY);
    end

    logic [CW-1:0]          pos_ext;
    logic [LB-1:0]          num;
    logic [SAMPLE_BITS-1:0] mag;
    afg_pkg::flags_t        fl;

    always_comb begin
        pos_ext        = CW'(position);
        fl.neg         = sample_in[SAMPLE_BITS-1];
        fl.beyond      = pos_ext >= CW'(track_len_reg);
        num            = track_len_reg - LB'(1) - pos_ext[LB-1:0];
        fl.fade_in_on  = !fl.beyond && (pos_ext < CW'(fade_in_reg));
        fl.fade_out_on = !fl.beyond && (num < fade_out_reg);
        mag            = fl.neg ? (~sample_in + SAMPLE_BITS'(1)) : sample_in;
        item = {fl, mag,
                fl.fade_in_on  ? pos_ext[LB-1:0] : LB'(0),
                fl.fade_out_on ? num : LB'(0)};
    end
endmodule
`default_nettype wire

@@ rtl/afg_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// afg_queue
// two-entry queue between classification and arithmetic
// ----------------------------------------------------------------------------
module afg_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             wr_valid,
    output      logic             wr_ready,
    input  wire logic [WIDTH-1:0] wr_data,
    output      logic             rd_valid,
    input  wire logic             rd_ready,
    output      logic [WIDTH-1:0] rd_data
);
    logic [WIDTH-1:0] mem_reg [0:1];
    logic             wp_reg, rp_reg;
    logic [1:0]       cnt_reg;
    logic             push, pop;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data  = mem_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= !wp_reg;
            if (pop)  rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule
`default_nettype wire

@@ rtl/afg_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// afg_back
// pipelined ramp dividers, then fade-in, fade-out and gain scaling
// ----------------------------------------------------------------------------
module afg_back #(
    parameter int SAMPLE_BITS        = afg_pkg::SAMPLE_BITS,
    parameter int RAMP_FRACTION_BITS = afg_pkg::RAMP_FRACTION_BITS,
    parameter int ITEM_BITS          = 4 + SAMPLE_BITS + 2 * afg_pkg::LEN_BITS
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   in_valid,
    output      logic                   in_ready,
    input  wire logic [ITEM_BITS-1:0]   in_item,
    input  wire afg_pkg::cfg_t          cfg,
    output      logic                   out_valid,
    input  wire logic                   out_ready,
    output      logic [SAMPLE_BITS-1:0] out_sample,
    output      logic                   out_beyond
);
    localparam int LB = afg_pkg::LEN_BITS;
    localparam int F  = RAMP_FRACTION_BITS;
    localparam int SB = SAMPLE_BITS;
    localparam int GB = afg_pkg::GAIN_BITS;
    localparam logic [SB-1:0] LIM = {1'b0, {(SB-1){1'b1}}};

    logic en;
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // divider pipeline
    logic            v_reg  [0:F];
    afg_pkg::flags_t fl_reg [0:F];
    logic [SB-1:0]   mg_reg [0:F];
    logic [LB-1:0]   ri_reg [0:F];
    logic [LB-1:0]   ro_reg [0:F];
    logic [F-1:0]    qi_reg [0:F];
    logic [F-1:0]    qo_reg [0:F];
    logic [LB-1:0]   ri_next [0:F-1];
    logic [LB-1:0]   ro_next [0:F-1];
    logic            bi_next [0:F-1];
    logic            bo_next [0:F-1];

    for (genvar k = 0; k < F; k++) begin : g_div
        logic [LB:0] ti, to;
        always_comb begin
            ti = {ri_reg[k], 1'b0};
            to = {ro_reg[k], 1'b0};
            bi_next[k] = ti >= {1'b0, cfg.fade_in_len};
            bo_next[k] = to >= {1'b0, cfg.fade_out_len};
            ri_next[k] = bi_next[k] ? LB'(ti - {1'b0, cfg.fade_in_len}) : ti[LB-1:0];
            ro_next[k] = bo_next[k] ? LB'(to - {1'b0, cfg.fade_out_len}) : to[LB-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= F; k++) v_reg[k] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
            for (int k = 0; k < F; k++) v_reg[k+1] <= v_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            {fl_reg[0], mg_reg[0], ri_reg[0], ro_reg[0]} <= in_item;
            qi_reg[0] <= '0;
            qo_reg[0] <= '0;
            for (int k = 0; k < F; k++) begin
                fl_reg[k+1] <= fl_reg[k];
                mg_reg[k+1] <= mg_reg[k];
                ri_reg[k+1] <= ri_next[k];
                ro_reg[k+1] <= ro_next[k];
                qi_reg[k+1] <= {qi_reg[k][F-2:0], bi_next[k]};
                qo_reg[k+1] <= {qo_reg[k][F-2:0], bo_next[k]};
            end
        end
    end

    // scaling stages: multiply, then shift and saturate
    logic [4:0]      sv_reg;
    afg_pkg::flags_t f1_reg, f2_reg, f3_reg, f4_reg, f5_reg;
    logic [SB-1:0]   m2_reg, m4_reg;
    logic [F-1:0]    qo1_reg, qo2_reg;
    logic [SB-1:0]   byp1_reg, byp3_reg, byp5_reg;
    logic [SB+F-1:0] p1_reg, p3_reg;
    logic [SB+GB-1:0] p5_reg;
    logic [SB+F-1:0] sh1, sh3;
    logic [SB+GB-1:0] sh5;
    logic [SB-1:0]   m2_next, m4_next, m6_next;
    logic            out_valid_reg, out_beyond_reg;
    logic [SB-1:0]   out_sample_reg;

    always_comb begin
        sh1 = p1_reg >> F;
        sh3 = p3_reg >> F;
        sh5 = p5_reg >> afg_pkg::GAIN_FRAC;
        m2_next = !f1_reg.fade_in_on ? byp1_reg :
                  (sh1 > (SB+F)'(LIM)) ? LIM : sh1[SB-1:0];
        m4_next = !f3_reg.fade_out_on ? byp3_reg :
                  (sh3 > (SB+F)'(LIM)) ? LIM : sh3[SB-1:0];
        m6_next = !cfg.gain_on ? byp5_reg :
                  (sh5 > (SB+GB)'(LIM)) ? LIM : sh5[SB-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sv_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            sv_reg        <= {sv_reg[3:0], v_reg[F]};
            out_valid_reg <= sv_reg[4];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_reg   <= fl_reg[F];
            byp1_reg <= mg_reg[F];
            qo1_reg  <= qo_reg[F];
            p1_reg   <= mg_reg[F] * qi_reg[F];
            f2_reg   <= f1_reg;
            m2_reg   <= m2_next;
            qo2_reg  <= qo1_reg;
            f3_reg   <= f2_reg;
            byp3_reg <= m2_reg;
            p3_reg   <= m2_reg * qo2_reg;
            f4_reg   <= f3_reg;
            m4_reg   <= m4_next;
            f5_reg   <= f4_reg;
            byp5_reg <= m4_reg;
            p5_reg   <= m4_reg * cfg.gain_eff;
            out_beyond_reg <= f5_reg.beyond;
            out_sample_reg <= f5_reg.beyond ? '0 :
                              f5_reg.neg ? (~m6_next + SB'(1)) : m6_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign out_beyond = out_beyond_reg;
endmodule
`default_nettype wire

@@ rtl/afg_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// afg_checker
// port-level checks on the fade and gain stage
// ----------------------------------------------------------------------------
module afg_checker #(
    parameter int SAMPLE_BITS = afg_pkg::SAMPLE_BITS,
    parameter int M_DATA_BITS = 16
) (
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   s_tready,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready,
    input wire logic [M_DATA_BITS-1:0] m_tdata,
    input wire logic [0:0]             m_tuser
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_beyond_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[SAMPLE_BITS-1:0] == '0)
        else $error("beyond-end result not zero");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("not empty after reset");
endmodule

bind audio_fade_gain_stage_core afg_checker #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .M_DATA_BITS (M_DATA_BITS)
) u_afg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// fade-in, fade-out and gain checks of audio_fade_gain_stage_core: a table of
// directed samples, then random bursts of samples under several register
// settings, every result compared with a predicted sample and end flag
// ----------------------------------------------------------------------------
module testbench;

    localparam int LATENCY = afg_pkg::RAMP_FRACTION_BITS + 7;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int N_RANDOM = 1400;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               beyond;
    } fade_result_t;

    typedef struct {
        logic signed [15:0] sample;
        logic [30:0]        pos;
        logic               known;
        logic signed [15:0] want;
        logic               want_beyond;
    } stim_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [afg_pkg::CFG_IDX_BITS-1:0] cfg_addr = '0;
    logic [afg_pkg::CFG_BITS-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [47:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [0:0] m_tuser;

    logic [30:0] track_len_q, fade_in_len_q, fade_out_len_q;
    logic [15:0] gain_q;
    logic        gain_en_q;

    fade_result_t expected_samples[$];
    int mismatches = 0;
    int idle_cycles = 0;
    bit long_hold = 1'b0;
    int hold_count = 0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    audio_fade_gain_stage_core i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    function automatic logic signed [15:0] scale(logic signed [15:0] s,
                                                 logic [63:0] factor, int frac);
        logic [63:0] mag;
        logic [63:0] p;
        mag = s[15] ? 64'(-32'(s)) : 64'(s);
        p = (mag * factor) >> frac;
        if (p > 64'd32767) p = 64'd32767;
        return s[15] ? -16'(p) : 16'(p);
    endfunction

    function automatic fade_result_t faded_sample(logic signed [15:0] s,
                                                  logic [30:0] pos);
        fade_result_t r;
        logic [63:0] g;
        r.beyond = 1'b0;
        if (pos >= track_len_q) begin
            r.sample = '0;
            r.beyond = 1'b1;
            return r;
        end
        if (pos < fade_in_len_q)
            s = scale(s, (64'(pos) << afg_pkg::RAMP_FRACTION_BITS)
                      / 64'(fade_in_len_q), afg_pkg::RAMP_FRACTION_BITS);
        if (fade_out_len_q != 0 &&
            64'(signed'({1'b0, pos})) > 64'(signed'({1'b0, track_len_q})) - 1
                - 64'(signed'({1'b0, fade_out_len_q})))
            s = scale(s, (64'(track_len_q - 31'd1 - pos) << afg_pkg::RAMP_FRACTION_BITS)
                      / 64'(fade_out_len_q), afg_pkg::RAMP_FRACTION_BITS);
        g = (gain_q > afg_pkg::GAIN_MAX) ? 64'(afg_pkg::GAIN_MAX) : 64'(gain_q);
        if (gain_en_q && g != 64'(afg_pkg::GAIN_UNITY))
            s = scale(s, g, afg_pkg::GAIN_FRAC);
        r.sample = s;
        return r;
    endfunction

    // write enable stays high; the caller drops it after the last write
    task automatic write_reg(afg_pkg::cfg_idx_t idx, logic [30:0] value);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        case (idx)
            afg_pkg::REG_TRACK_LEN:    track_len_q = value;
            afg_pkg::REG_FADE_IN_LEN:  fade_in_len_q = value;
            afg_pkg::REG_FADE_OUT_LEN: fade_out_len_q = value;
            afg_pkg::REG_GAIN:         gain_q = value[15:0];
            afg_pkg::REG_GAIN_ENABLED: gain_en_q = value[0];
            default: ;
        endcase
    endtask

    task automatic set_all(logic [30:0] tl, logic [30:0] fi, logic [30:0] fo,
                           logic [15:0] g, logic ge);
        write_reg(afg_pkg::REG_TRACK_LEN, tl);
        write_reg(afg_pkg::REG_FADE_IN_LEN, fi);
        write_reg(afg_pkg::REG_FADE_OUT_LEN, fo);
        write_reg(afg_pkg::REG_GAIN, 31'(g));
        write_reg(afg_pkg::REG_GAIN_ENABLED, 31'(ge));
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (expected_samples.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    // one transaction, held until accepted
    task automatic send_sample(logic signed [15:0] s, logic [30:0] pos);
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, pos, s};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_samples.push_back(faded_sample(s, pos));
    endtask

    task automatic random_gap();
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 6)) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // receiver stall pattern and the long hold-off
    always @(posedge aclk) begin
        if (long_hold) begin
            m_tready <= 1'b0;
            hold_count <= hold_count + 1;
            if (hold_count >= 120) begin
                long_hold <= 1'b0;
                hold_count <= 0;
            end
        end else begin
            m_tready <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 63) == 0);
        end
    end

    // result check
    always @(posedge aclk) begin
        fade_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_samples.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result sample %0d flag %0d",
                             $signed(m_tdata), m_tuser);
            end else begin
                want = expected_samples.pop_front();
                if (m_tdata !== want.sample || m_tuser[0] !== want.beyond) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("expected sample %0d flag %0d, got %0d flag %0d",
                                 want.sample, want.beyond, $signed(m_tdata),
                                 m_tuser[0]);
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("audio_fade_gain_stage_core: mismatch");
            $finish;
        end
    end

    stim_row_t rows[$];

    function automatic stim_row_t row(logic signed [15:0] s, logic [30:0] p,
                                      logic k, logic signed [15:0] w, logic wb);
        stim_row_t r;
        r.sample = s; r.pos = p; r.known = k; r.want = w; r.want_beyond = wb;
        return r;
    endfunction

    initial begin
        fade_result_t got;
        logic [30:0] tl, p;
        int n;
        track_len_q = '0; fade_in_len_q = '0; fade_out_len_q = '0;
        gain_q = afg_pkg::GAIN_UNITY; gain_en_q = 1'b1;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // after reset every position is beyond the end
        send_sample(16'sd1234, 31'd0);
        s_tvalid <= 1'b0;
        drain();

        set_all(31'd100, 31'd10, 31'd10, afg_pkg::GAIN_UNITY, 1'b1);
        rows.push_back(row(16'sd32767, 31'd50, 1'b1, 16'sd32767, 1'b0));
        rows.push_back(row(-16'sd32768, 31'd50, 1'b1, -16'sd32768, 1'b0));
        rows.push_back(row(16'sd32767, 31'd0, 1'b1, 16'sd0, 1'b0));
        rows.push_back(row(-16'sd32768, 31'd99, 1'b1, 16'sd0, 1'b0));
        rows.push_back(row(16'sd500, 31'd100, 1'b1, 16'sd0, 1'b1));
        rows.push_back(row(16'sd500, 31'h7fffffff, 1'b1, 16'sd0, 1'b1));
        rows.push_back(row(-16'sd32768, 31'd5, 1'b0, 16'sd0, 1'b0));
        rows.push_back(row(16'sd32767, 31'd9, 1'b0, 16'sd0, 1'b0));
        rows.push_back(row(-16'sd1, 31'd90, 1'b0, 16'sd0, 1'b0));
        rows.push_back(row(-16'sd32768, 31'd95, 1'b0, 16'sd0, 1'b0));
        foreach (rows[i]) begin
            send_sample(rows[i].sample, rows[i].pos);
            got = expected_samples[$];
            if (rows[i].known && (got.sample !== rows[i].want ||
                                  got.beyond !== rows[i].want_beyond)) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("table row %0d predicts %0d, expected %0d", i,
                             got.sample, rows[i].want);
            end
        end
        s_tvalid <= 1'b0;
        drain();

        // gain extremes, gain above range, disabled gain, overlapping fades
        set_all(31'd8, 31'd8, 31'd8, afg_pkg::GAIN_MAX, 1'b1);
        for (int i = 0; i < 9; i++) send_sample(i[0] ? -16'sd32768 : 16'sd32767, 31'(i));
        send_sample(-16'sd32768, 31'd4);
        s_tvalid <= 1'b0;
        drain();
        set_all(31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 16'hffff, 1'b1);
        send_sample(16'sd32767, 31'h3fffffff);
        send_sample(-16'sd32768, 31'h7ffffffe);
        s_tvalid <= 1'b0;
        drain();
        write_reg(afg_pkg::REG_GAIN, 31'd0);
        cfg_we <= 1'b0;
        send_sample(-16'sd32768, 31'h40000000);
        s_tvalid <= 1'b0;
        drain();
        write_reg(afg_pkg::REG_GAIN_ENABLED, 31'd0);
        cfg_we <= 1'b0;
        send_sample(16'sd32767, 31'h40000000);
        s_tvalid <= 1'b0;
        drain();

        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                0: set_all(31'd64, 31'd16, 31'd16, 16'd20000, 1'b1);
                1: set_all(31'd200, 31'd0, 31'd50, afg_pkg::GAIN_MAX, 1'b1);
                2: set_all(31'd40, 31'd40, 31'd0, 16'd8000, 1'b1);
                3: set_all(31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 16'hffff, 1'b1);
                4: set_all(31'd1, 31'd1, 31'd1, 16'd0, 1'b0);
                5: set_all(31'd300, 31'd120, 31'd130, 16'd24576, 1'b1);
                default: set_all(31'($urandom_range(1, 2000)),
                                 31'($urandom_range(0, 2000)),
                                 31'($urandom_range(0, 2000)),
                                 16'($urandom_range(0, 65535)), 1'($urandom));
            endcase
            tl = track_len_q;
            n = 0;
            if (phase == 5) long_hold <= 1'b1;
            while (n < N_RANDOM / 7) begin
                repeat ($urandom_range(1, 20)) begin
                    case ($urandom_range(0, 9))
                        0: p = 31'($urandom);
                        1: p = tl + 31'($urandom_range(0, 3));
                        2: p = 31'(tl - 31'($urandom_range(1, 4)));
                        default: p = (tl > 0) ? 31'(64'($urandom) % 64'(tl)) : '0;
                    endcase
                    send_sample(16'($urandom), p);
                    n++;
                end
                random_gap();
            end
            s_tvalid <= 1'b0;
            drain();
        end

        if (mismatches == 0)
            $display("audio_fade_gain_stage_core: match");
        else
            $display("audio_fade_gain_stage_core: mismatch");
        $finish;
    end

endmodule
`default_nettype wire
